/* rtl/rsc_pkg.sv */
// shared types, widths and reset values for the ramp/soak setpoint sequencer
// no dependencies; imported by every rtl module of the block
package rsc_pkg;

  localparam int unsigned TickWidthDef  = 24;
  localparam int unsigned QueueDepthDef = 2;

  localparam int unsigned CmdW     = 2;
  localparam int unsigned TempW    = 27;
  localparam int unsigned StepW    = 24;
  localparam int unsigned LimW     = 24;
  localparam int unsigned CycTotW  = 8;
  localparam int unsigned CycW     = 9;
  localparam int unsigned PhaseW   = 4;
  localparam int unsigned PtW      = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 27;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2,
    CMD_SKIP  = 2'd3
  } cmd_e;

  typedef enum logic [PhaseW-1:0] {
    PH_STOPPED     = 4'd0,
    PH_HEAT_INIT   = 4'd1,
    PH_HEAT        = 4'd2,
    PH_SOAK_INIT   = 4'd3,
    PH_SOAK        = 4'd4,
    PH_COOL_INIT   = 4'd5,
    PH_COOL        = 4'd6,
    PH_NEXT_CYCLE  = 4'd7,
    PH_FINISH_INIT = 4'd8,
    PH_FINISHED    = 4'd9
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RAMP_STEP      = 3'd0,
    REG_TEMP_MAX       = 3'd1,
    REG_TEMP_MIN       = 3'd2,
    REG_SOAK_TICKS     = 3'd3,
    REG_HEAT_TICKS_MAX = 3'd4,
    REG_COOL_TICKS_MAX = 3'd5,
    REG_CYCLE_TOTAL    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic        [StepW-1:0]   ramp_step;
    logic signed [TempW-1:0]   temp_max;
    logic signed [TempW-1:0]   temp_min;
    logic        [LimW-1:0]    soak_ticks;
    logic        [LimW-1:0]    heat_ticks_max;
    logic        [LimW-1:0]    cool_ticks_max;
    logic        [CycTotW-1:0] cycle_total;
  } cfg_t;

  // decoded command word as it travels through the queue
  typedef struct packed {
    cmd_e                    op;
    logic signed [TempW-1:0] meas;
    logic                    cold;
  } cmd_t;

  localparam logic        [StepW-1:0]   RampStepRst    = 24'd364;
  localparam logic signed [TempW-1:0]   TempMaxRst     = 27'sd5242880;
  localparam logic signed [TempW-1:0]   TempMinRst     = 27'sd2621440;
  localparam logic        [LimW-1:0]    SoakTicksRst   = 24'd14400;
  localparam logic        [LimW-1:0]    HeatTicksRst   = 24'd21600;
  localparam logic        [LimW-1:0]    CoolTicksRst   = 24'd21600;
  localparam logic        [CycTotW-1:0] CycleTotalRst  = 8'd1;

  localparam logic signed [TempW-1:0]   SetpointMax    = {1'b0, {(TempW-1){1'b1}}};
  localparam logic        [CycW-1:0]    CycleMax       = {CycW{1'b1}};

endpackage

/* rtl/ramp_soak_cycle_setpoint_sequencer_core.sv */
// a command passes the queue, then the state registers once the result slot is free
// throughput: one command per cycle while each result is popped as it appears
// the two-entry command queue lets push continue while a result waits to be popped
// reset: phase stopped, setpoint, tick count and cycle cleared, registers at defaults
// depends on rsc_pkg, rsc_regs, rsc_front, rsc_fifo, rsc_back
module ramp_soak_cycle_setpoint_sequencer_core import rsc_pkg::*; #(
  parameter int unsigned TickWidth  = TickWidthDef,
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push,
  output logic                    full,
  input  logic [CmdW-1:0]         cmd_i,
  input  logic signed [TempW-1:0] measured_temp_i,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [TempW-1:0] setpoint_o,
  output logic [PhaseW-1:0]       phase_o,
  output logic [CycW-1:0]         cycle_number_o,
  output logic [PtW-1:0]          phase_ticks_o,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CfgDataW-1:0]     cfg_data_i
);

  cfg_t cfg;
  cmd_t q_wr_data, q_rd_data;
  logic q_wr, q_rd, q_empty, q_full;

  rsc_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rsc_front u_front (
    .push            (push),
    .full            (full),
    .cmd_i           (cmd_i),
    .measured_temp_i (measured_temp_i),
    .temp_min_i      (cfg.temp_min),
    .q_full_i        (q_full),
    .q_wr_o          (q_wr),
    .q_data_o        (q_wr_data)
  );

  rsc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (q_wr),
    .wr_data_i (q_wr_data),
    .rd_i      (q_rd),
    .rd_data_o (q_rd_data),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  rsc_back #(
    .TickWidth (TickWidth)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_empty_i      (q_empty),
    .q_data_i       (q_rd_data),
    .q_rd_o         (q_rd),
    .empty          (empty),
    .pop            (pop),
    .setpoint_o     (setpoint_o),
    .phase_o        (phase_o),
    .cycle_number_o (cycle_number_o),
    .phase_ticks_o  (phase_ticks_o)
  );

endmodule

/* rtl/rsc_regs.sv */
// configuration register file of the setpoint sequencer
// depends on rsc_pkg
module rsc_regs import rsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_RAMP_STEP:      cfg_d.ramp_step      = cfg_data_i[StepW-1:0];
        REG_TEMP_MAX:       cfg_d.temp_max       = $signed(cfg_data_i[TempW-1:0]);
        REG_TEMP_MIN:       cfg_d.temp_min       = $signed(cfg_data_i[TempW-1:0]);
        REG_SOAK_TICKS:     cfg_d.soak_ticks     = cfg_data_i[LimW-1:0];
        REG_HEAT_TICKS_MAX: cfg_d.heat_ticks_max = cfg_data_i[LimW-1:0];
        REG_COOL_TICKS_MAX: cfg_d.cool_ticks_max = cfg_data_i[LimW-1:0];
        REG_CYCLE_TOTAL:    cfg_d.cycle_total    = cfg_data_i[CycTotW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ramp_step      <= RampStepRst;
      cfg_q.temp_max       <= TempMaxRst;
      cfg_q.temp_min       <= TempMinRst;
      cfg_q.soak_ticks     <= SoakTicksRst;
      cfg_q.heat_ticks_max <= HeatTicksRst;
      cfg_q.cool_ticks_max <= CoolTicksRst;
      cfg_q.cycle_total    <= CycleTotalRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/rsc_front.sv */
// front end: accepts commands, decodes them and flags a cold chamber
// depends on rsc_pkg; feeds the command queue
module rsc_front import rsc_pkg::*; (
  input  logic                    push,
  output logic                    full,
  input  logic [CmdW-1:0]         cmd_i,
  input  logic signed [TempW-1:0] measured_temp_i,
  input  logic signed [TempW-1:0] temp_min_i,
  input  logic                    q_full_i,
  output logic                    q_wr_o,
  output cmd_t                    q_data_o
);

  assign full   = q_full_i;
  assign q_wr_o = push && !q_full_i;

  // the cooling exit compare is done here so the back end stays shallow
  always_comb begin
    q_data_o.op   = cmd_e'(cmd_i);
    q_data_o.meas = measured_temp_i;
    q_data_o.cold = measured_temp_i < temp_min_i;
  end

endmodule

/* rtl/rsc_fifo.sv */
// short queue of decoded commands between front and back end
// depends on rsc_pkg
module rsc_fifo import rsc_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_i,
  input  cmd_t wr_data_i,
  input  logic rd_i,
  output cmd_t rd_data_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* rtl/rsc_back.sv */
// back end: phase state, one command step per cycle unless stalled
// depends on rsc_pkg; state registers double as the result word
module rsc_back import rsc_pkg::*; #(
  parameter int unsigned TickWidth = TickWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  logic                    q_empty_i,
  input  cmd_t                    q_data_i,
  output logic                    q_rd_o,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [TempW-1:0] setpoint_o,
  output logic [PhaseW-1:0]       phase_o,
  output logic [CycW-1:0]         cycle_number_o,
  output logic [PtW-1:0]          phase_ticks_o
);

  localparam int unsigned CmpW = (TickWidth > LimW) ? TickWidth : LimW;

  phase_e                  phase_q, phase_d;
  logic signed [TempW-1:0] setpoint_q, setpoint_d;
  logic [TickWidth-1:0]    elapsed_q, elapsed_d;
  logic [CycW-1:0]         cycle_q, cycle_d;
  logic                    out_valid_q, out_valid_d;

  logic                    take;
  logic [TickWidth-1:0]    elapsed_inc;
  logic signed [TempW:0]   ramp_sum;
  logic signed [TempW-1:0] ramp_sp;
  logic [CycW-1:0]         cycle_inc;
  logic                    heat_done, soak_done, cool_done;

  // a word is taken whenever the result slot is free or being drained
  assign take   = !q_empty_i && (!out_valid_q || pop);
  assign q_rd_o = take;

  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
  assign cycle_inc   = (cycle_q == CycleMax) ? cycle_q : cycle_q + 1'b1;

  assign ramp_sum = $signed({setpoint_q[TempW-1], setpoint_q})
                  + $signed({{(TempW + 1 - StepW){1'b0}}, cfg_i.ramp_step});
  // only positive overflow is possible when adding an unsigned step
  assign ramp_sp  = (ramp_sum[TempW:TempW-1] == 2'b01) ? SetpointMax
                                                       : ramp_sum[TempW-1:0];

  assign heat_done = (ramp_sp >= cfg_i.temp_max)
                  || (CmpW'(elapsed_inc) > CmpW'(cfg_i.heat_ticks_max));
  assign soak_done = CmpW'(elapsed_inc) > CmpW'(cfg_i.soak_ticks);
  assign cool_done = (CmpW'(elapsed_inc) > CmpW'(cfg_i.cool_ticks_max)) || q_data_i.cold;

  always_comb begin
    phase_d    = phase_q;
    setpoint_d = setpoint_q;
    elapsed_d  = elapsed_q;
    cycle_d    = cycle_q;
    if (take) begin
      case (q_data_i.op)
        CMD_TICK: begin
          elapsed_d = elapsed_inc;
          case (phase_q)
            PH_HEAT_INIT: begin
              setpoint_d = q_data_i.meas;
              elapsed_d  = '0;
              phase_d    = PH_HEAT;
            end
            PH_HEAT: begin
              setpoint_d = ramp_sp;
              if (heat_done) phase_d = PH_SOAK_INIT;
            end
            PH_SOAK_INIT: begin
              elapsed_d = '0;
              phase_d   = PH_SOAK;
            end
            PH_SOAK: begin
              setpoint_d = cfg_i.temp_max;
              if (soak_done) phase_d = PH_COOL_INIT;
            end
            PH_COOL_INIT: begin
              setpoint_d = '0;
              elapsed_d  = '0;
              phase_d    = PH_COOL;
            end
            PH_COOL: begin
              setpoint_d = '0;
              if (cool_done) phase_d = PH_NEXT_CYCLE;
            end
            PH_NEXT_CYCLE: begin
              cycle_d = cycle_inc;
              phase_d = (cycle_inc > {1'b0, cfg_i.cycle_total}) ? PH_FINISH_INIT
                                                                : PH_HEAT_INIT;
            end
            PH_FINISH_INIT: begin
              setpoint_d = '0;
              phase_d    = PH_FINISHED;
            end
            PH_STOPPED, PH_FINISHED: begin
              setpoint_d = '0;
              elapsed_d  = '0;
              cycle_d    = '0;
            end
            default: begin
              // unused codes fall back to stopped
              phase_d    = PH_STOPPED;
              setpoint_d = '0;
              elapsed_d  = '0;
              cycle_d    = '0;
            end
          endcase
        end
        CMD_START: begin
          if (phase_q inside {PH_STOPPED, PH_FINISHED}) begin
            phase_d = PH_HEAT_INIT;
            cycle_d = CycW'(1);
          end
        end
        CMD_STOP: begin
          phase_d    = PH_STOPPED;
          cycle_d    = '0;
          setpoint_d = '0;
        end
        CMD_SKIP: begin
          if (phase_q inside {PH_HEAT, PH_SOAK, PH_COOL}) begin
            phase_d = phase_e'(phase_q + 1'b1);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_STOPPED;
      setpoint_q  <= '0;
      elapsed_q   <= '0;
      cycle_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      setpoint_q  <= setpoint_d;
      elapsed_q   <= elapsed_d;
      cycle_q     <= cycle_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty          = !out_valid_q;
  assign setpoint_o     = setpoint_q;
  assign phase_o        = phase_q;
  assign cycle_number_o = cycle_q;
  assign phase_ticks_o  = PtW'(elapsed_q);

  a_cool_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_COOL |-> setpoint_q == '0)
    else $error("setpoint not zero while cooling");

  a_stopped_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_STOPPED |-> (setpoint_q == '0 && cycle_q == '0))
    else $error("stopped with live setpoint or cycle");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop |=> $stable(setpoint_q) && $stable(phase_q)
                            && $stable(elapsed_q) && $stable(cycle_q))
    else $error("state moved under a pending result");

endmodule

/* tb/tb_ramp_soak_cycle_setpoint_sequencer_core.sv */
// self-checking testbench for ramp_soak_cycle_setpoint_sequencer_core
// bursty push driver, stalling pop monitor, in-bench phase sequencer predictor
// depends on rsc_pkg and the core rtl only
`timescale 1ns / 1ps

module tb_ramp_soak_cycle_setpoint_sequencer_core;
  import rsc_pkg::*;

  localparam int unsigned    ItemsPerSetting = 210;
  localparam int unsigned    CycleLimit      = 400000;
  localparam int unsigned    PrintCap        = 40;
  localparam longint         TempLow         = -13107200;
  localparam longint         TempHigh        = 65536000;
  localparam longint         SpCeil          = longint'(SetpointMax);
  localparam longint         SpFloor         = -longint'(SetpointMax) - 1;
  localparam logic [PtW-1:0] TickSat         = '1;

  typedef struct {
    cmd_e                    op;
    logic signed [TempW-1:0] meas;
  } chamber_cmd_t;

  typedef struct {
    logic signed [TempW-1:0] setpoint;
    phase_e                  phase;
    logic [CycW-1:0]         cycle;
    logic [PtW-1:0]          ticks;
  } setpoint_word_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    push = 1'b0;
  logic                    full;
  logic [CmdW-1:0]         cmd_i = '0;
  logic signed [TempW-1:0] measured_temp_i = '0;
  logic                    empty;
  logic                    pop = 1'b0;
  logic signed [TempW-1:0] setpoint_o;
  logic [PhaseW-1:0]       phase_o;
  logic [CycW-1:0]         cycle_number_o;
  logic [PtW-1:0]          phase_ticks_o;
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx_i = '0;
  logic [CfgDataW-1:0]     cfg_data_i = '0;

  ramp_soak_cycle_setpoint_sequencer_core u_dut (.*);

  // predictor state and its copy of the registers
  cfg_t           chamber_cfg;
  phase_e         seq_phase;
  longint         seq_setpoint;
  logic [PtW-1:0] seq_ticks;
  logic [CycW-1:0] seq_cycle;
  logic [15:0]    phases_seen;

  chamber_cmd_t   pending_cmds[$];
  setpoint_word_t expected_words[$];
  chamber_cmd_t   next_cmd;
  setpoint_word_t want;

  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned settings_run;
  int unsigned cycle_count;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned stall_mode;
  int unsigned mode_count;
  bit          send_now;
  bit          pop_next;

  function automatic setpoint_word_t advance_sequencer(cmd_e op, logic signed [TempW-1:0] meas);
    setpoint_word_t w;
    case (op)
      CMD_TICK: begin
        if (seq_ticks != TickSat) seq_ticks++;
        if (seq_phase == PH_STOPPED || seq_phase == PH_FINISHED) begin
          seq_setpoint = 0;
          seq_ticks    = '0;
          seq_cycle    = '0;
        end
        case (seq_phase)
          PH_HEAT_INIT: begin
            seq_setpoint = longint'(meas);
            seq_ticks    = '0;
            seq_phase    = PH_HEAT;
          end
          PH_HEAT: begin
            seq_setpoint += longint'(chamber_cfg.ramp_step);
            if (seq_setpoint > SpCeil) seq_setpoint = SpCeil;
            if (seq_setpoint >= longint'($signed(chamber_cfg.temp_max)) ||
                seq_ticks > chamber_cfg.heat_ticks_max) seq_phase = PH_SOAK_INIT;
          end
          PH_SOAK_INIT: begin
            seq_ticks = '0;
            seq_phase = PH_SOAK;
          end
          PH_SOAK: begin
            seq_setpoint = longint'($signed(chamber_cfg.temp_max));
            if (seq_ticks > chamber_cfg.soak_ticks) seq_phase = PH_COOL_INIT;
          end
          PH_COOL_INIT: begin
            seq_setpoint = 0;
            seq_ticks    = '0;
            seq_phase    = PH_COOL;
          end
          PH_COOL: begin
            seq_setpoint = 0;
            if (seq_ticks > chamber_cfg.cool_ticks_max ||
                $signed(meas) < $signed(chamber_cfg.temp_min)) seq_phase = PH_NEXT_CYCLE;
          end
          PH_NEXT_CYCLE: begin
            if (seq_cycle != CycleMax) seq_cycle++;
            seq_phase = (seq_cycle > {1'b0, chamber_cfg.cycle_total}) ? PH_FINISH_INIT
                                                                      : PH_HEAT_INIT;
          end
          PH_FINISH_INIT: begin
            seq_setpoint = 0;
            seq_phase    = PH_FINISHED;
          end
          default: seq_setpoint = 0;
        endcase
        if (seq_setpoint > SpCeil) seq_setpoint = SpCeil;
        if (seq_setpoint < SpFloor) seq_setpoint = SpFloor;
      end
      CMD_START: begin
        if (seq_phase == PH_STOPPED || seq_phase == PH_FINISHED) begin
          seq_phase = PH_HEAT_INIT;
          seq_cycle = 1;
        end
      end
      CMD_STOP: begin
        seq_phase    = PH_STOPPED;
        seq_cycle    = '0;
        seq_setpoint = 0;
      end
      default: begin
        case (seq_phase)
          PH_HEAT: seq_phase = PH_SOAK_INIT;
          PH_SOAK: seq_phase = PH_COOL_INIT;
          PH_COOL: seq_phase = PH_NEXT_CYCLE;
          default: ;
        endcase
      end
    endcase
    phases_seen[seq_phase] = 1'b1;
    w.setpoint = seq_setpoint[TempW-1:0];
    w.phase    = seq_phase;
    w.cycle    = seq_cycle;
    w.ticks    = seq_ticks;
    return w;
  endfunction

  function automatic void report_mismatch(string field, longint want_v, longint got_v);
    mismatches++;
    if (mismatches <= PrintCap)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
  endfunction

  // temperatures spread over the range, near the heat end point and around the cool threshold
  function automatic logic signed [TempW-1:0] pick_temp();
    longint t;
    case ($urandom_range(0, 3))
      0, 1: t = longint'($urandom_range(0, 78643200)) + TempLow;
      2: t = longint'($signed(chamber_cfg.temp_max)) - longint'($urandom_range(0, 2000000));
      default: t = longint'($signed(chamber_cfg.temp_min)) +
                   longint'($urandom_range(0, 400000)) - 200000;
    endcase
    if (t < TempLow) t = TempLow;
    if (t > TempHigh) t = TempHigh;
    return t[TempW-1:0];
  endfunction

  task automatic queue_cmd(cmd_e op, longint t);
    chamber_cmd_t c;
    c.op   = op;
    c.meas = t[TempW-1:0];
    pending_cmds.push_back(c);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_RAMP_STEP:      chamber_cfg.ramp_step      = data[StepW-1:0];
      REG_TEMP_MAX:       chamber_cfg.temp_max       = data;
      REG_TEMP_MIN:       chamber_cfg.temp_min       = data;
      REG_SOAK_TICKS:     chamber_cfg.soak_ticks     = data[LimW-1:0];
      REG_HEAT_TICKS_MAX: chamber_cfg.heat_ticks_max = data[LimW-1:0];
      REG_COOL_TICKS_MAX: chamber_cfg.cool_ticks_max = data[LimW-1:0];
      default:            chamber_cfg.cycle_total    = data[CycTotW-1:0];
    endcase
  endtask

  task automatic apply_setting(longint step, longint tmax, longint tmin, longint soak,
                               longint heat, longint cool, longint cycles);
    write_reg(REG_RAMP_STEP, CfgDataW'(step));
    write_reg(REG_TEMP_MAX, CfgDataW'(tmax));
    write_reg(REG_TEMP_MIN, CfgDataW'(tmin));
    write_reg(REG_SOAK_TICKS, CfgDataW'(soak));
    write_reg(REG_HEAT_TICKS_MAX, CfgDataW'(heat));
    write_reg(REG_COOL_TICKS_MAX, CfgDataW'(cool));
    write_reg(REG_CYCLE_TOTAL, CfgDataW'(cycles));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_run++;
  endtask

  // mostly start followed by a run of ticks, with skips, stops and stray starts mixed in
  task automatic queue_programs(int unsigned count);
    int unsigned n;
    int unsigned roll;
    cmd_e        op;
    n = 0;
    while (n < count) begin
      queue_cmd(CMD_START, pick_temp());
      n++;
      repeat ($urandom_range(8, 70)) begin
        roll = $urandom_range(0, 99);
        if (roll < 84) op = CMD_TICK;
        else if (roll < 92) op = CMD_SKIP;
        else if (roll < 96) op = CMD_START;
        else op = CMD_STOP;
        queue_cmd(op, pick_temp());
        n++;
      end
    end
  endtask

  // sampled on the falling edge so the driver's queue and push have settled
  task automatic drain();
    @(negedge clk_i);
    while (pending_cmds.size() != 0 || push || expected_words.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    chamber_cfg = '{RampStepRst, TempMaxRst, TempMinRst, SoakTicksRst, HeatTicksRst,
                    CoolTicksRst, CycleTotalRst};
    seq_phase    = PH_STOPPED;
    seq_setpoint = 0;
    seq_ticks    = '0;
    seq_cycle    = '0;
    phases_seen  = '0;
    mismatches   = 0;
    words_checked = 0;
    settings_run = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // short program: saturating heat from the top of the range, ignored commands,
    // skips out of each phase, a second heat-soak-cool pass, restart from finished, stop
    apply_setting(24'hFFFFFF, TempHigh, TempLow, 1, 2, 1, 2);
    queue_cmd(CMD_TICK, TempHigh);
    queue_cmd(CMD_SKIP, 0);
    queue_cmd(CMD_START, 0);
    queue_cmd(CMD_START, 0);
    queue_cmd(CMD_SKIP, 0);
    queue_cmd(CMD_TICK, TempHigh);
    queue_cmd(CMD_TICK, TempHigh);
    queue_cmd(CMD_TICK, TempHigh);
    queue_cmd(CMD_TICK, TempHigh);
    queue_cmd(CMD_SKIP, 0);
    queue_cmd(CMD_TICK, TempLow);
    queue_cmd(CMD_TICK, TempLow);
    queue_cmd(CMD_TICK, TempLow);
    queue_cmd(CMD_TICK, TempLow);
    queue_cmd(CMD_TICK, TempLow);
    queue_cmd(CMD_SKIP, 0);
    queue_cmd(CMD_TICK, TempLow);
    queue_cmd(CMD_SKIP, 0);
    queue_cmd(CMD_TICK, TempLow);
    queue_cmd(CMD_SKIP, 0);
    queue_cmd(CMD_TICK, TempLow);
    queue_cmd(CMD_TICK, TempLow);
    queue_cmd(CMD_START, TempHigh);
    queue_cmd(CMD_STOP, TempHigh);
    queue_cmd(CMD_TICK, -1);
    drain();

    for (int s = 0; s < 7; s++) begin
      case (s)
        0: apply_setting(0, TempLow, TempLow, 0, 0, 0, 1);
        1: apply_setting(24'hFFFFFF, TempHigh, TempHigh, 24'hFFFFFF, 24'hFFFFFF,
                         24'hFFFFFF, 255);
        // zero cycle count runs a single cycle
        2: apply_setting($urandom_range(0, 3000000), longint'($urandom_range(0, 78643200)) +
                         TempLow, longint'($urandom_range(0, 78643200)) + TempLow,
                         $urandom_range(0, 15), $urandom_range(0, 15),
                         $urandom_range(0, 15), 0);
        default: apply_setting(($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                                           : $urandom_range(0, 3000000),
                               longint'($urandom_range(0, 78643200)) + TempLow,
                               longint'($urandom_range(0, 78643200)) + TempLow,
                               $urandom_range(0, 15), $urandom_range(0, 15),
                               $urandom_range(0, 15), $urandom_range(1, 5));
      endcase
      queue_programs(ItemsPerSetting);
      drain();
    end

    $display("checked %0d result words under %0d register settings, %0d mismatches",
             words_checked, settings_run, mismatches);
    $display("phase codes reached (bit per code): %b", phases_seen[9:0]);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("ramp_soak_cycle_setpoint_sequencer_core verification clean");
    else
      $display("ramp_soak_cycle_setpoint_sequencer_core verification failed");
    $finish;
  end

  // sender: bursts of random length separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push       <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (push && !full)
        expected_words.push_back(advance_sequencer(cmd_e'(cmd_i), measured_temp_i));
      if (!(push && full)) begin
        send_now = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
          if (gap_left == 0) begin
            next_cmd = pending_cmds.pop_front();
            send_now = 1'b1;
            burst_left--;
          end
        end
        push <= send_now;
        if (send_now) begin
          cmd_i           <= next_cmd.op;
          measured_temp_i <= next_cmd.meas;
        end
      end
    end
  end

  // receiver: stall behavior is redrawn at random among three modes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop        <= 1'b0;
      stall_left = 0;
      stall_mode = 0;
      mode_count = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= PrintCap)
            $display("%0t: unexpected word, setpoint %0d phase %0d", $time,
                     setpoint_o, phase_o);
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (setpoint_o !== want.setpoint)
            report_mismatch("setpoint", longint'(want.setpoint), longint'(setpoint_o));
          if (phase_o !== want.phase)
            report_mismatch("phase", longint'(want.phase), longint'(phase_o));
          if (cycle_number_o !== want.cycle)
            report_mismatch("cycle_number", longint'(want.cycle), longint'(cycle_number_o));
          if (phase_ticks_o !== want.ticks)
            report_mismatch("phase_ticks", longint'(want.ticks), longint'(phase_ticks_o));
        end
      end
      mode_count++;
      if (mode_count % 256 == 0) stall_mode = $urandom_range(0, 2);
      if (stall_left > 0) begin
        stall_left--;
        pop_next = 1'b0;
      end else begin
        pop_next = 1'b1;
        case (stall_mode)
          1: if ($urandom_range(0, 1) == 1) stall_left = 1;
          2: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(4, 15);
          default: ;
        endcase
      end
      pop <= pop_next;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("ramp_soak_cycle_setpoint_sequencer_core verification failed");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
